// File: hw/rtl/bba_pkg.sv
package bba_pkg;

   localparam int MIN_BLOCK_ORDER = 6;
   localparam int MAX_POOL_ORDER  = 20;
   localparam int HEADER_BYTES    = 32;

   localparam int UNIT_BITS  = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
   localparam int UNIT_COUNT = 1 << UNIT_BITS;
   localparam int LIST_COUNT = MAX_POOL_ORDER + 1;

   localparam int OP_WIDTH     = 1;
   localparam int SIZE_WIDTH   = 21;
   localparam int OFFSET_WIDTH = 20;
   localparam int STATUS_WIDTH = 3;
   localparam int ORDER_WIDTH  = 5;

   typedef logic [OP_WIDTH-1:0]     op_type;
   typedef logic [SIZE_WIDTH-1:0]   size_type;
   typedef logic [OFFSET_WIDTH-1:0] offset_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;
   typedef logic [ORDER_WIDTH-1:0]  order_type;

   localparam op_type OP_ALLOC = 1'b0;
   localparam op_type OP_FREE  = 1'b1;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_ZERO      = 3'd1;
   localparam status_type ST_TOO_LARGE = 3'd2;
   localparam status_type ST_NO_BLOCK  = 3'd3;
   localparam status_type ST_BAD_FREE  = 3'd4;

   typedef enum logic [1:0] {
      TAG_UNUSED   = 2'd0,
      TAG_AVAIL    = 2'd1,
      TAG_RESERVED = 2'd2
   } tag_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_A_SIZE,
      S_A_SCAN,
      S_A_RD,
      S_A_UNLINK,
      S_A_UNLINK_N,
      S_A_SPLIT,
      S_A_SPLIT_H,
      S_A_DONE,
      S_F_RD,
      S_F_CHK,
      S_F_BRD,
      S_F_BCHK,
      S_F_UNLINK,
      S_F_UNLINK_N,
      S_F_PUSH,
      S_F_PUSH_H,
      S_RESP
   } state_type;

endpackage

// File: hw/rtl/bba_if.sv
interface bba_req_if;
   import bba_pkg::*;
   logic       valid;
   logic       ready;
   op_type     operation;
   size_type   request_size;
   offset_type user_offset;
   modport source (output valid, operation, request_size, user_offset, input ready);
   modport sink   (input valid, operation, request_size, user_offset, output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   offset_type granted_offset;
   modport source (output valid, status, granted_offset, input ready);
   modport sink   (input valid, status, granted_offset, output ready);
endinterface

// File: hw/rtl/bba_ram.sv
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/buddy_block_allocator_core.sv
// Buddy allocator over a pool of 2^pool_order bytes (64-byte units).
// req channel: operation (0 alloc, 1 free), request_size, user_offset.
// rsp channel: one word per request with status and granted_offset.
// Config: csr_we/csr_wdata write pool_order (clamped to 6..20) and
//   restart the pool as one free block; write only while idle.
// After reset (and after a pool_order write) a clearing pass walks all
//   unit records, one per cycle, while req_ready is low.
// One request at a time; the time from acceptance to rsp_valid is set by
//   the registered read of the record RAM and the walk over the orders:
//   alloc checks the size, scans the free lists, unlinks the block found
//   and splits it down, fixing a successor if it has one. free checks
//   the offset and record, then merges with free buddies, unlinking each
//   from its list, and pushes the result. Errors go straight to the response.
// The response word is held in an output register until rsp_ready; no
//   new request is taken while it waits, and the next one is taken the
//   cycle after the response word is accepted.
module buddy_block_allocator_core #(
   parameter int MinOrder = bba_pkg::MIN_BLOCK_ORDER,
   parameter int MaxOrder = bba_pkg::MAX_POOL_ORDER,
   parameter int HeaderBytes = bba_pkg::HEADER_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   bba_req_if.sink               req,
   bba_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [bba_pkg::ORDER_WIDTH-1:0] csr_wdata
);
   import bba_pkg::*;

   localparam int UB    = MaxOrder - MinOrder;
   localparam int UN    = 1 << UB;
   localparam int LC    = MaxOrder + 1;
   localparam int OW    = ORDER_WIDTH;
   // record: tag, order, has_next, has_prev, next, prev
   localparam int RW    = 2 + OW + 2 + 2 * UB;

   typedef logic [UB-1:0] unit_type;

   typedef struct packed {
      tag_type   tag;
      order_type ord;
      logic      hn;
      logic      hp;
      unit_type  nx;
      unit_type  pv;
   } rec_type;

   state_type state_ff, state_in;
   order_type pool_ff, pool_in;
   unit_type  heads_ff [LC];
   logic      hv_ff    [LC];
   logic [UB:0] clr_ff, clr_in;

   size_type   size_ff, size_in;
   offset_type uoff_ff, uoff_in;
   order_type  k_ff, k_in, j_ff, j_in;
   unit_type   u_ff, u_in, b_ff, b_in;
   rec_type    cur_ff, cur_in;
   status_type st_ff, st_in;
   offset_type go_ff, go_in;
   logic       rv_ff, rv_in;
   logic [1:0] sub_ff, sub_in;

   logic     we;
   unit_type wa, ra;
   rec_type  wd, rd;
   logic [RW-1:0] rd_raw;

   bba_ram #(.WIDTH(RW), .DEPTH(UN)) u_rec (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd_raw)
   );
   assign rd = rec_type'(rd_raw);

   function automatic order_type clamp(input order_type v);
      if (v < order_type'(MinOrder)) return order_type'(MinOrder);
      if (v > order_type'(MaxOrder)) return order_type'(MaxOrder);
      return v;
   endfunction

   function automatic unit_type ubit(input order_type o);
      return unit_type'(1) << (o - order_type'(MinOrder));
   endfunction

   // head list update requests
   logic      hw_en;
   order_type hw_k;
   unit_type  hw_u;
   logic      hw_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         pool_ff  <= clamp(order_type'(MaxOrder));
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < LC; i++) begin
            hv_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         pool_ff  <= pool_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         if (csr_we) begin
            for (int i = 0; i < LC; i++) begin
               hv_ff[i] <= 1'b0;
            end
         end else if (hw_en) begin
            hv_ff[hw_k] <= hw_v;
         end
      end
      if (hw_en) begin
         heads_ff[hw_k] <= hw_u;
      end
      size_ff <= size_in;
      uoff_ff <= uoff_in;
      k_ff   <= k_in;
      j_ff   <= j_in;
      u_ff   <= u_in;
      b_ff   <= b_in;
      cur_ff <= cur_in;
      st_ff  <= st_in;
      go_ff  <= go_in;
      sub_ff <= sub_in;
   end

   logic [SIZE_WIDTH:0] need;
   logic [MaxOrder:0]   pbytes;
   logic [OFFSET_WIDTH:0] off;
   assign need   = {1'b0, size_ff} + (SIZE_WIDTH+1)'(HeaderBytes);
   assign off    = {1'b0, uoff_ff} - (OFFSET_WIDTH+1)'(HeaderBytes);

   rec_type avail_rec;

   always_comb begin
      state_in = state_ff;
      pool_in  = pool_ff;
      clr_in   = clr_ff;
      rv_in    = rv_ff;
      size_in  = size_ff;
      uoff_in  = uoff_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      u_in     = u_ff;
      b_in     = b_ff;
      cur_in   = cur_ff;
      st_in    = st_ff;
      go_in    = go_ff;
      sub_in   = sub_ff;
      we = 1'b0;
      wa = '0;
      wd = '0;
      ra = u_ff;
      hw_en = 1'b0;
      hw_k  = '0;
      hw_u  = '0;
      hw_v  = 1'b0;
      pbytes = '0;
      avail_rec = '0;

      case (state_ff)
         S_INIT: begin
            we = 1'b1;
            wa = clr_ff[UB-1:0];
            wd = '0;
            if (clr_ff[UB]) begin
               wa = '0;
               wd.tag = TAG_AVAIL;
               wd.ord = pool_ff;
               hw_en = 1'b1;
               hw_k = pool_ff;
               hw_u = '0;
               hw_v = 1'b1;
               state_in = S_IDLE;
            end
            clr_in = clr_ff + (UB+1)'(1);
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               size_in = req.request_size;
               uoff_in = req.user_offset;
               state_in = (req.operation == OP_ALLOC) ? S_A_SIZE : S_F_RD;
               k_in = order_type'(MinOrder);
            end
         end
         S_A_SIZE: begin
            pbytes = '0;
            pbytes[pool_ff] = 1'b1;
            go_in = '0;
            if (size_ff == '0) begin
               st_in = ST_ZERO; state_in = S_RESP;
            end else if ({1'b0, size_ff} > (SIZE_WIDTH+1)'(pbytes)) begin
               st_in = ST_TOO_LARGE; state_in = S_RESP;
            end else if (((SIZE_WIDTH+2)'(1) << k_ff) < (SIZE_WIDTH+2)'(need)
                         && k_ff <= order_type'(MaxOrder)) begin
               k_in = k_ff + order_type'(1);
            end else if (k_ff > pool_ff) begin
               st_in = ST_TOO_LARGE; state_in = S_RESP;
            end else begin
               j_in = k_ff;
               state_in = S_A_SCAN;
            end
         end
         S_A_SCAN: begin
            if (j_ff > pool_ff) begin
               st_in = ST_NO_BLOCK; state_in = S_RESP;
            end else if (!hv_ff[j_ff]) begin
               j_in = j_ff + order_type'(1);
            end else begin
               u_in = heads_ff[j_ff];
               state_in = S_A_RD;
               sub_in = 2'd0;
            end
         end
         S_A_RD: begin
            // sub 0: issue read of u, sub 1: data ready
            ra = u_ff;
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else begin
               cur_in = rd;
               state_in = S_A_UNLINK;
               sub_in = 2'd0;
            end
         end
         S_A_UNLINK: begin
            // head of list: new head is next
            hw_en = 1'b1;
            hw_k = j_ff;
            hw_u = cur_ff.nx;
            hw_v = cur_ff.hn;
            we = 1'b1;
            wa = u_ff;
            wd = cur_ff;
            wd.tag = TAG_RESERVED;
            wd.hn = 1'b0;
            wd.hp = 1'b0;
            cur_in = wd;
            ra = cur_ff.nx;
            if (cur_ff.hn) begin
               state_in = S_A_UNLINK_N;
               sub_in = 2'd0;
            end else begin
               state_in = S_A_SPLIT;
            end
         end
         S_A_UNLINK_N: begin
            // old next becomes the list head
            we = 1'b1;
            wa = cur_ff.nx;
            wd = rd;
            wd.hp = 1'b0;
            state_in = S_A_SPLIT;
         end
         S_A_SPLIT: begin
            if (j_ff > k_ff) begin
               j_in = j_ff - order_type'(1);
               b_in = u_ff + ubit(j_ff - order_type'(1));
               state_in = S_A_SPLIT_H;
               sub_in = 2'd0;
            end else begin
               state_in = S_A_DONE;
            end
         end
         S_A_SPLIT_H: begin
            // push b onto list j; fix old head prev
            if (sub_ff == 2'd0) begin
               ra = heads_ff[j_ff];
               sub_in = 2'd1;
            end else begin
               if (hv_ff[j_ff] && sub_ff == 2'd1) begin
                  we = 1'b1;
                  wa = heads_ff[j_ff];
                  wd = rd;
                  wd.hp = 1'b1;
                  wd.pv = b_ff;
                  sub_in = 2'd2;
               end else begin
                  we = 1'b1;
                  wa = b_ff;
                  wd = '0;
                  wd.tag = TAG_AVAIL;
                  wd.ord = j_ff;
                  wd.hn = hv_ff[j_ff];
                  wd.nx = heads_ff[j_ff];
                  hw_en = 1'b1;
                  hw_k = j_ff;
                  hw_u = b_ff;
                  hw_v = 1'b1;
                  state_in = S_A_SPLIT;
               end
            end
         end
         S_A_DONE: begin
            we = 1'b1;
            wa = u_ff;
            wd = cur_ff;
            wd.ord = k_ff;
            st_in = ST_OK;
            go_in = offset_type'(({{(OFFSET_WIDTH-UB){1'b0}}, u_ff} << MinOrder)
                                 + OFFSET_WIDTH'(HeaderBytes));
            state_in = S_RESP;
         end
         S_F_RD: begin
            go_in = '0;
            pbytes = '0;
            pbytes[pool_ff] = 1'b1;
            u_in = unit_type'(off[OFFSET_WIDTH-1:0] >> MinOrder);
            if (uoff_ff < OFFSET_WIDTH'(HeaderBytes)
                || off[MinOrder-1:0] != '0
                || off >= (OFFSET_WIDTH+1)'(pbytes)) begin
               st_in = ST_BAD_FREE; state_in = S_RESP;
            end else begin
               state_in = S_F_CHK;
               sub_in = 2'd0;
            end
         end
         S_F_CHK: begin
            ra = u_ff;
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else if (rd.tag != TAG_RESERVED) begin
               st_in = ST_BAD_FREE; state_in = S_RESP;
            end else begin
               k_in = (rd.ord < order_type'(MinOrder)) ? order_type'(MinOrder) :
                      (rd.ord > pool_ff) ? pool_ff : rd.ord;
               we = 1'b1;
               wa = u_ff;
               wd = rd;
               wd.tag = TAG_UNUSED;
               state_in = S_F_BRD;
               sub_in = 2'd0;
            end
         end
         S_F_BRD: begin
            if (k_ff < pool_ff) begin
               b_in = u_ff ^ ubit(k_ff);
               state_in = S_F_BCHK;
               sub_in = 2'd0;
            end else begin
               state_in = S_F_PUSH;
               sub_in = 2'd0;
            end
         end
         S_F_BCHK: begin
            ra = b_ff;
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else if (rd.tag != TAG_AVAIL || rd.ord != k_ff) begin
               state_in = S_F_PUSH;
               sub_in = 2'd0;
            end else begin
               cur_in = rd;
               state_in = S_F_UNLINK;
               sub_in = 2'd0;
            end
         end
         S_F_UNLINK: begin
            // sub0: fix head or read prev; sub3: fix prev; sub1: read next; sub2: fix next
            case (sub_ff)
               2'd0: begin
                  if (cur_ff.hp) begin
                     ra = cur_ff.pv;
                     sub_in = 2'd3;
                  end else begin
                     hw_en = 1'b1;
                     hw_k = k_ff;
                     hw_u = cur_ff.nx;
                     hw_v = cur_ff.hn;
                     sub_in = 2'd1;
                  end
               end
               2'd3: begin
                  we = 1'b1;
                  wa = cur_ff.pv;
                  wd = rd;
                  wd.nx = cur_ff.nx;
                  wd.hn = cur_ff.hn;
                  sub_in = 2'd1;
               end
               2'd1: begin
                  ra = cur_ff.nx;
                  if (cur_ff.hn) begin
                     sub_in = 2'd2;
                  end else begin
                     state_in = S_F_UNLINK_N;
                  end
               end
               2'd2: begin
                  we = 1'b1;
                  wa = cur_ff.nx;
                  wd = rd;
                  wd.pv = cur_ff.pv;
                  wd.hp = cur_ff.hp;
                  state_in = S_F_UNLINK_N;
               end
               default: ;
            endcase
         end
         S_F_UNLINK_N: begin
            we = 1'b1;
            wa = b_ff;
            wd = cur_ff;
            wd.tag = TAG_UNUSED;
            wd.hn = 1'b0;
            wd.hp = 1'b0;
            if (b_ff < u_ff) u_in = b_ff;
            k_in = k_ff + order_type'(1);
            state_in = S_F_BRD;
         end
         S_F_PUSH: begin
            ra = heads_ff[k_ff];
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else begin
               if (hv_ff[k_ff]) begin
                  we = 1'b1;
                  wa = heads_ff[k_ff];
                  wd = rd;
                  wd.hp = 1'b1;
                  wd.pv = u_ff;
               end
               state_in = S_F_PUSH_H;
            end
         end
         S_F_PUSH_H: begin
            ra = u_ff;
            avail_rec = '0;
            avail_rec.tag = TAG_AVAIL;
            avail_rec.ord = k_ff;
            avail_rec.hn = hv_ff[k_ff];
            avail_rec.nx = heads_ff[k_ff];
            we = 1'b1;
            wa = u_ff;
            wd = avail_rec;
            hw_en = 1'b1;
            hw_k = k_ff;
            hw_u = u_ff;
            hw_v = 1'b1;
            st_in = ST_OK;
            go_in = '0;
            state_in = S_RESP;
         end
         S_RESP: begin
            rv_in = 1'b1;
            if (rv_ff && rsp.ready) begin
               rv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_we) begin
         pool_in  = clamp(csr_wdata);
         clr_in   = '0;
         state_in = S_INIT;
      end
   end

   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rv_ff;
   assign rsp.status         = st_ff;
   assign rsp.granted_offset = go_ff;

endmodule
